// ===== src/dual_channel_rms_gain_meter_top_defines.svh =====
// assertion macros shared by the meter's rtl
`ifndef DUAL_CHANNEL_RMS_GAIN_METER_TOP_DEFINES_SVH
`define DUAL_CHANNEL_RMS_GAIN_METER_TOP_DEFINES_SVH

// same-cycle implication
`define DCRGM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcrgm check failed");

// next-cycle implication
`define DCRGM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcrgm check failed");

`endif

// ===== src/dcrgm_pkg.sv =====
`default_nettype none
package dcrgm_pkg;

    localparam int SUM_W = 23;
    localparam int SQ_W = 35;
    localparam int ACC_W = 27;
    localparam int DIV_W = 51;
    localparam int PA_W = 51;
    localparam int PB_W = 50;
    localparam int Q16_W = 32;
    localparam int MV_W = 16;
    localparam int DC_W = 12;
    localparam int BAND_W = 23;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [17:0] TWO_SQRT2_Q16 = 18'd185364;

    localparam logic [11:0] RST_FRAME_PAIRS = 12'd1960;
    localparam logic [7:0]  RST_SKIP_PAIRS = 8'd0;
    localparam logic [7:0]  RST_FRAMES_AVG = 8'd100;
    localparam logic [23:0] RST_RMS_SCALE = 24'd344330;
    localparam logic [23:0] RST_DC_SCALE = 24'd44800;
    localparam logic [9:0]  RST_DC_OFFSET = 10'd70;
    localparam logic [15:0] RST_TARGET = 16'd0;
    localparam logic [7:0]  WIPER_RESET = 8'd127;
    localparam logic [7:0]  WIPER_MAX = 8'd254;
    localparam logic [7:0]  WIPER_MIN = 8'd1;
    localparam logic [15:0] TARGET_MIN_MV = 16'd1000;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_PAIRS = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SKIP_PAIRS = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAMES_AVG = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_IN_SCALE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_SCALE = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DC_SCALE = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_DC_OFFSET = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET = 3'd7;

    localparam logic [1:0] STEP_HOLD = 2'd0;
    localparam logic [1:0] STEP_UP = 2'd1;
    localparam logic [1:0] STEP_DOWN = 2'd2;

    typedef enum logic [1:0] {
        DIV_VAR   = 2'd0,
        DIV_SHIFT = 2'd1,
        DIV_DC    = 2'd2,
        DIV_AVG   = 2'd3
    } div_src_t;

    typedef struct packed {
        logic     accept;
        logic     mul_frame;
        logic     div_start;
        div_src_t div_src;
        logic     sqrt_start;
        logic     acc_add;
        logic     dc_mul;
        logic     dc_store;
        logic     frame_clear;
        logic     frame_inc;
        logic     avg_mul;
        logic     avg_clamp;
        logic     vpp_mul;
        logic     res_store;
        logic     period_done;
        logic     ch;
    } cmd_t;

    typedef struct packed {
        logic frame_end;
        logic period_end;
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ===== src/dcrgm_div.sv =====
`default_nettype none
module dcrgm_div #(
    parameter int DW = 51,
    parameter int VW = 12
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               busy,
    output logic [DW-1:0]      quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] q_reg, q_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] d_reg;
    logic [VW:0]   rem_sh;
    logic          ge;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_sh = {rem_reg, q_reg[DW-1]};
        ge = rem_sh >= {1'b0, d_reg};
        rem_next = ge ? VW'(rem_sh - {1'b0, d_reg}) : VW'(rem_sh);
        q_next = {q_reg[DW-2:0], ge};
        cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(DW);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            rem_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy)
        begin
            q_reg <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = cnt_reg != '0;
    assign quotient = q_reg;
endmodule
`default_nettype wire

// ===== src/dcrgm_sqrt.sv =====
`default_nettype none
module dcrgm_sqrt #(
    parameter int IW = 51
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [IW-1:0]        radicand,
    output logic                      busy,
    output logic [(IW+1)/2-1:0]       root
);
    localparam int RW = (IW + 1) / 2;
    localparam int PW = 2 * RW;
    localparam int CW = $clog2(RW + 1);

    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] x_reg;
    logic [RW-1:0] root_reg;
    logic [RW-1:0] rem_reg;
    logic [RW+1:0] rem_sh, trial;
    logic          ge;

    // one root bit per cycle from two radicand bits
    always_comb
    begin
        rem_sh = {rem_reg, x_reg[PW-1:PW-2]};
        trial = {root_reg, 2'b01};
        ge = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(RW);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= PW'(radicand);
            root_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy)
        begin
            x_reg <= {x_reg[PW-3:0], 2'b00};
            root_reg <= {root_reg[RW-2:0], ge};
            rem_reg <= ge ? RW'(rem_sh - trial) : RW'(rem_sh);
        end
    end

    assign busy = cnt_reg != '0;
    assign root = root_reg;
endmodule
`default_nettype wire

// ===== src/dcrgm_datapath.sv =====
`default_nettype none
module dcrgm_datapath import dcrgm_pkg::*; #(
    parameter int MAX_FRAME_PAIRS = 2048,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   cmd,
    output status_t                     status,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic [SAMPLE_BITS-1:0] in_sample,
    input  wire logic [SAMPLE_BITS-1:0] out_sample,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic [MV_W-1:0]             in_rms_mv,
    output logic [MV_W-1:0]             out_rms_mv,
    output logic [MV_W-1:0]             in_vpp_mv,
    output logic [MV_W-1:0]             out_vpp_mv,
    output logic [DC_W-1:0]             in_dc_mv,
    output logic [DC_W-1:0]             out_dc_mv,
    output logic [1:0]                  gain_step,
    output logic [7:0]                  pot_position,
    output logic                        target_too_low
);
    localparam int NW = $clog2(MAX_FRAME_PAIRS + 1);
    localparam int DVW = (NW > 8) ? NW : 8;
    localparam int CMP_W = 14;
    localparam int RTW = (DIV_W + 1) / 2;
    localparam int DCT_W = DIV_W - 16;

    // configuration
    logic [11:0] frame_pairs_reg;
    logic [7:0]  skip_pairs_reg;
    logic [7:0]  frames_avg_reg;
    logic [23:0] in_scale_reg, out_scale_reg, dc_scale_reg;
    logic [9:0]  dc_offset_reg;
    logic [15:0] target_reg;

    // running state
    logic [SUM_W-1:0] in_sum_reg, out_sum_reg;
    logic [SQ_W-1:0]  in_sq_reg, out_sq_reg;
    logic [11:0]      pair_cnt_reg;
    logic [7:0]       frame_cnt_reg;
    logic [ACC_W-1:0] in_acc_reg, out_acc_reg;
    logic [7:0]       wiper_reg, wiper_next;
    logic             out_valid_reg;

    // work registers
    logic [PA_W-1:0]  prod_a_reg;
    logic [PB_W-1:0]  prod_b_reg;
    logic [Q16_W-1:0] q16_reg;
    logic [MV_W-1:0]  res_rms_reg [2];
    logic [MV_W-1:0]  res_vpp_reg [2];
    logic [DC_W-1:0]  res_dc_reg [2];

    logic [NW-1:0]          n_eff;
    logic [7:0]             f_eff;
    logic [2*SAMPLE_BITS-1:0] in_sq_term, out_sq_term;
    logic [SUM_W-1:0]       sel_sum;
    logic [SQ_W-1:0]        sel_sq;
    logic [ACC_W-1:0]       sel_acc;
    logic [23:0]            sel_scale;
    logic [PA_W-1:0]        diff;
    logic [DIV_W-1:0]       div_dividend, div_quo;
    logic [DVW-1:0]         div_divisor;
    logic                   div_busy, sqrt_busy;
    logic [RTW-1:0]         root;
    logic [ACC_W:0]         acc_sum;
    logic [ACC_W-1:0]       acc_new;
    logic [DCT_W-1:0]       dc_t;
    logic [DC_W-1:0]        dc_val;
    logic [Q16_W-1:0]       q16_val;
    logic [MV_W-1:0]        vpp_val;
    logic [BAND_W-1:0]      vpp_x100, tgt_x101, tgt_x99;
    logic [7:0]             w_up, w_dn;
    logic [1:0]             step_val;
    logic                   too_low;

    always_comb
    begin
        if (frame_pairs_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if ({1'b0, frame_pairs_reg} > 13'(MAX_FRAME_PAIRS))
        begin
            n_eff = NW'(MAX_FRAME_PAIRS);
        end
        else
        begin
            n_eff = NW'(frame_pairs_reg);
        end
        f_eff = (frames_avg_reg == '0) ? 8'd1 : frames_avg_reg;

        status.frame_end = CMP_W'(pair_cnt_reg) + CMP_W'(1)
            >= CMP_W'(skip_pairs_reg) + CMP_W'(n_eff);
        status.period_end = {1'b0, frame_cnt_reg} + 9'd1 >= {1'b0, f_eff};
        status.div_busy = div_busy;
        status.sqrt_busy = sqrt_busy;
        status.out_free = !out_valid_reg || out_ready;

        in_sq_term = in_sample * in_sample;
        out_sq_term = out_sample * out_sample;

        sel_sum = cmd.ch ? out_sum_reg : in_sum_reg;
        sel_sq = cmd.ch ? out_sq_reg : in_sq_reg;
        sel_acc = cmd.ch ? out_acc_reg : in_acc_reg;
        sel_scale = cmd.ch ? out_scale_reg : in_scale_reg;

        // negative variance from inconsistent sums reads as zero
        diff = (prod_a_reg >= PA_W'(prod_b_reg)) ? prod_a_reg - PA_W'(prod_b_reg) : '0;

        unique case (cmd.div_src)
            DIV_VAR:   div_dividend = DIV_W'(diff);
            DIV_SHIFT: div_dividend = {div_quo[DIV_W-17:0], 16'b0};
            DIV_DC:    div_dividend = DIV_W'(prod_a_reg);
            DIV_AVG:   div_dividend = DIV_W'(sel_acc);
            default:   div_dividend = DIV_W'(diff);
        endcase
        div_divisor = (cmd.div_src == DIV_AVG) ? DVW'(f_eff) : DVW'(n_eff);

        acc_sum = (ACC_W+1)'(sel_acc) + (ACC_W+1)'(root);
        acc_new = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

        dc_t = div_quo[DIV_W-1:16] + DCT_W'(dc_offset_reg);
        dc_val = (|dc_t[DCT_W-1:DC_W]) ? '1 : dc_t[DC_W-1:0];

        q16_val = (|prod_a_reg[PA_W-1:40]) ? '1 : prod_a_reg[39:8];
        vpp_val = (|prod_b_reg[PB_W-1:48]) ? '1 : prod_b_reg[47:32];

        // gain band against the input peak-to-peak value
        vpp_x100 = BAND_W'(res_vpp_reg[0]) * BAND_W'(100);
        tgt_x101 = BAND_W'(target_reg) * BAND_W'(101);
        tgt_x99 = BAND_W'(target_reg) * BAND_W'(99);
        w_up = wiper_reg + 8'd1;
        w_dn = wiper_reg - 8'd1;
        too_low = target_reg < TARGET_MIN_MV;
        step_val = STEP_HOLD;
        wiper_next = wiper_reg;
        if (too_low)
        begin
            wiper_next = WIPER_MAX;
        end
        else if (vpp_x100 > tgt_x101)
        begin
            step_val = STEP_UP;
            wiper_next = (w_up > WIPER_MAX) ? WIPER_MIN : w_up;
        end
        else if (vpp_x100 < tgt_x99)
        begin
            step_val = STEP_DOWN;
            wiper_next = (w_dn < WIPER_MIN) ? WIPER_MAX : w_dn;
        end
    end

    dcrgm_div #(
        .DW (DIV_W),
        .VW (DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    dcrgm_sqrt #(
        .IW (DIV_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (div_quo),
        .busy     (sqrt_busy),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pairs_reg <= RST_FRAME_PAIRS;
            skip_pairs_reg <= RST_SKIP_PAIRS;
            frames_avg_reg <= RST_FRAMES_AVG;
            in_scale_reg <= RST_RMS_SCALE;
            out_scale_reg <= RST_RMS_SCALE;
            dc_scale_reg <= RST_DC_SCALE;
            dc_offset_reg <= RST_DC_OFFSET;
            target_reg <= RST_TARGET;
            in_sum_reg <= '0;
            out_sum_reg <= '0;
            in_sq_reg <= '0;
            out_sq_reg <= '0;
            pair_cnt_reg <= '0;
            frame_cnt_reg <= '0;
            in_acc_reg <= '0;
            out_acc_reg <= '0;
            wiper_reg <= WIPER_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_FRAME_PAIRS: frame_pairs_reg <= cfg_wdata[11:0];
                    REG_SKIP_PAIRS:  skip_pairs_reg <= cfg_wdata[7:0];
                    REG_FRAMES_AVG:  frames_avg_reg <= cfg_wdata[7:0];
                    REG_IN_SCALE:    in_scale_reg <= cfg_wdata;
                    REG_OUT_SCALE:   out_scale_reg <= cfg_wdata;
                    REG_DC_SCALE:    dc_scale_reg <= cfg_wdata;
                    REG_DC_OFFSET:   dc_offset_reg <= cfg_wdata[9:0];
                    REG_TARGET:      target_reg <= cfg_wdata[15:0];
                    default:         target_reg <= target_reg;
                endcase
            end

            if (cmd.accept)
            begin
                if (pair_cnt_reg >= 12'(skip_pairs_reg))
                begin
                    in_sum_reg <= in_sum_reg + SUM_W'(in_sample);
                    out_sum_reg <= out_sum_reg + SUM_W'(out_sample);
                    in_sq_reg <= in_sq_reg + SQ_W'(in_sq_term);
                    out_sq_reg <= out_sq_reg + SQ_W'(out_sq_term);
                end
                if (!status.frame_end)
                begin
                    pair_cnt_reg <= pair_cnt_reg + 12'd1;
                end
            end

            if (cmd.frame_clear)
            begin
                in_sum_reg <= '0;
                out_sum_reg <= '0;
                in_sq_reg <= '0;
                out_sq_reg <= '0;
                pair_cnt_reg <= '0;
            end
            if (cmd.frame_inc)
            begin
                frame_cnt_reg <= frame_cnt_reg + 8'd1;
            end

            if (cmd.acc_add)
            begin
                if (cmd.ch)
                begin
                    out_acc_reg <= acc_new;
                end
                else
                begin
                    in_acc_reg <= acc_new;
                end
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.period_done)
            begin
                in_acc_reg <= '0;
                out_acc_reg <= '0;
                frame_cnt_reg <= '0;
                wiper_reg <= wiper_next;
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_frame)
        begin
            prod_a_reg <= PA_W'(n_eff) * PA_W'(sel_sq);
            prod_b_reg <= PB_W'(sel_sum) * PB_W'(sel_sum);
        end
        if (cmd.dc_mul)
        begin
            prod_a_reg <= PA_W'(sel_sum) * PA_W'(dc_scale_reg);
        end
        if (cmd.avg_mul)
        begin
            prod_a_reg <= PA_W'(div_quo[ACC_W-1:0]) * PA_W'(sel_scale);
        end
        if (cmd.avg_clamp)
        begin
            q16_reg <= q16_val;
        end
        if (cmd.vpp_mul)
        begin
            prod_b_reg <= PB_W'(q16_reg) * PB_W'(TWO_SQRT2_Q16);
        end
        if (cmd.dc_store)
        begin
            res_dc_reg[cmd.ch] <= dc_val;
        end
        if (cmd.res_store)
        begin
            res_rms_reg[cmd.ch] <= q16_reg[31:16];
            res_vpp_reg[cmd.ch] <= vpp_val;
        end
        if (cmd.period_done)
        begin
            in_rms_mv <= res_rms_reg[0];
            out_rms_mv <= res_rms_reg[1];
            in_vpp_mv <= res_vpp_reg[0];
            out_vpp_mv <= res_vpp_reg[1];
            in_dc_mv <= res_dc_reg[0];
            out_dc_mv <= res_dc_reg[1];
            gain_step <= step_val;
            pot_position <= wiper_next;
            target_too_low <= too_low;
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

// ===== src/dcrgm_ctrl.sv =====
`default_nettype none
module dcrgm_ctrl import dcrgm_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);
    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_F_MUL   = 14'b00000000000010,
        S_F_SUB   = 14'b00000000000100,
        S_F_DIV1  = 14'b00000000001000,
        S_F_DIV2  = 14'b00000000010000,
        S_F_SQRT  = 14'b00000000100000,
        S_F_DCMUL = 14'b00000001000000,
        S_F_DCDIV = 14'b00000010000000,
        S_A_START = 14'b00000100000000,
        S_A_DIV   = 14'b00001000000000,
        S_A_CLAMP = 14'b00010000000000,
        S_A_VPP   = 14'b00100000000000,
        S_A_NEXT  = 14'b01000000000000,
        S_DECIDE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   ch_reg, ch_next;

    always_comb
    begin
        state_next = state_reg;
        ch_next = ch_reg;
        cmd = '0;
        cmd.div_src = DIV_VAR;
        cmd.ch = ch_reg;
        in_ready = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.frame_end)
                    begin
                        ch_next = 1'b0;
                        state_next = S_F_MUL;
                    end
                end
            end
            S_F_MUL:
            begin
                cmd.mul_frame = 1'b1;
                state_next = S_F_SUB;
            end
            S_F_SUB:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src = DIV_VAR;
                state_next = S_F_DIV1;
            end
            S_F_DIV1:
            begin
                if (!status.div_busy)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src = DIV_SHIFT;
                    state_next = S_F_DIV2;
                end
            end
            S_F_DIV2:
            begin
                if (!status.div_busy)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next = S_F_SQRT;
                end
            end
            S_F_SQRT:
            begin
                if (!status.sqrt_busy)
                begin
                    cmd.acc_add = 1'b1;
                    cmd.dc_mul = 1'b1;
                    state_next = S_F_DCMUL;
                end
            end
            S_F_DCMUL:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src = DIV_DC;
                state_next = S_F_DCDIV;
            end
            S_F_DCDIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.dc_store = 1'b1;
                    if (!ch_reg)
                    begin
                        ch_next = 1'b1;
                        state_next = S_F_MUL;
                    end
                    else
                    begin
                        cmd.frame_clear = 1'b1;
                        ch_next = 1'b0;
                        if (status.period_end)
                        begin
                            state_next = S_A_START;
                        end
                        else
                        begin
                            cmd.frame_inc = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_A_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src = DIV_AVG;
                state_next = S_A_DIV;
            end
            S_A_DIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.avg_mul = 1'b1;
                    state_next = S_A_CLAMP;
                end
            end
            S_A_CLAMP:
            begin
                cmd.avg_clamp = 1'b1;
                state_next = S_A_VPP;
            end
            S_A_VPP:
            begin
                cmd.vpp_mul = 1'b1;
                state_next = S_A_NEXT;
            end
            S_A_NEXT:
            begin
                cmd.res_store = 1'b1;
                if (!ch_reg)
                begin
                    ch_next = 1'b1;
                    state_next = S_A_START;
                end
                else
                begin
                    ch_next = 1'b0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.out_free)
                begin
                    cmd.period_done = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg <= ch_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/dual_channel_rms_gain_meter_top.sv =====
// dual channel true-rms meter with gain-step decision
// in channel: in_valid/in_ready carry one request, a pair of converter codes
// (amplifier input and output); a pair is taken in one cycle while accumulating
// at the last pair of a frame the meter stalls in_ready: per channel two
// divisions on the shared divider and a square root form the frame rms, and
// one more division forms the dc value; at the last frame of an averaging
// period there follow one division by the frame count and two multiplies per
// channel, then the band decision
// out channel: out_valid/out_ready, the result sits in an output register and
// new pairs keep being taken while it waits; if the next result is ready
// before the receiver takes the old one, the meter holds in its final step
// configuration: cfg_we/cfg_addr/cfg_wdata, to be written by the user only
// while idle; the block itself has no check for this
// reset: configuration returns to its defaults, sums, counters and
// accumulators clear, the wiper returns to mid scale
`default_nettype none
`include "dual_channel_rms_gain_meter_top_defines.svh"
module dual_channel_rms_gain_meter_top import dcrgm_pkg::*; #(
    parameter int MAX_FRAME_PAIRS = 2048,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] in_sample,
    input  wire logic [SAMPLE_BITS-1:0] out_sample,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [MV_W-1:0]             in_rms_mv,
    output logic [MV_W-1:0]             out_rms_mv,
    output logic [MV_W-1:0]             in_vpp_mv,
    output logic [MV_W-1:0]             out_vpp_mv,
    output logic [DC_W-1:0]             in_dc_mv,
    output logic [DC_W-1:0]             out_dc_mv,
    output logic [1:0]                  gain_step,
    output logic [7:0]                  pot_position,
    output logic                        target_too_low
);
    cmd_t    cmd;
    status_t status;

    // sequencer: accumulation, frame-end and period-end steps
    dcrgm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // sums, divider, root unit, scaling and the output register
    dcrgm_datapath #(
        .MAX_FRAME_PAIRS (MAX_FRAME_PAIRS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_sample      (in_sample),
        .out_sample     (out_sample),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .in_rms_mv      (in_rms_mv),
        .out_rms_mv     (out_rms_mv),
        .in_vpp_mv      (in_vpp_mv),
        .out_vpp_mv     (out_vpp_mv),
        .in_dc_mv       (in_dc_mv),
        .out_dc_mv      (out_dc_mv),
        .gain_step      (gain_step),
        .pot_position   (pot_position),
        .target_too_low (target_too_low)
    );

    // pairs are only taken with both iterative units at rest
    `DCRGM_ASSERT_IMP(a_ready_units_idle, in_ready, !status.div_busy && !status.sqrt_busy)
    // the divider is never restarted while running
    `DCRGM_ASSERT_IMP(a_div_not_busy, cmd.div_start, !status.div_busy)
    // a finished period always shows up on the output
    `DCRGM_ASSERT_NXT(a_result_shown, cmd.period_done, out_valid)
    // wiper stays inside its legal span
    `DCRGM_ASSERT_IMP(a_pot_range, out_valid, pot_position != 8'd0 && pot_position != 8'd255)
endmodule
`default_nettype wire
